// ----- design/ffba_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and codes for the first-fit block allocator.
// No dependencies; imported by the cell, the controller and the top level.
package ffba_pkg;

  localparam int REQ_W      = 11;
  localparam int OFF_W      = 10;
  localparam int ST_W       = 2;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 16;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_NOFIT   = 2'd1;
  localparam logic [ST_W-1:0] ST_BADFREE = 2'd2;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_ALLOC_SPLIT,
    OP_ALLOC_WHOLE,
    OP_MARK_FREE,
    OP_MERGE_NEXT,
    OP_MERGE_PREV
  } ffba_op_t;

  // Broadcast to every cell.
  typedef struct packed {
    ffba_op_t         op;
    logic [REQ_W-1:0] want;
    logic [OFF_W-1:0] offset;
  } ffba_ctl_t;

  // Per-cell position relative to the selected block.
  typedef struct packed {
    logic hit;        // this cell holds the selected block
    logic hit_left;   // the cell below holds it
    logic hit_right;  // the cell above holds it
    logic above;      // this cell lies above the selected one
  } ffba_sel_t;

endpackage

// ----- design/ffba_cell.sv -----
`timescale 1ns / 1ps
// One entry of the block table: header offset, payload size, used and valid marks.
// Shifts from either neighbor on insert or delete. Depends on ffba_pkg.
module ffba_cell #(
  parameter int AW           = 10,
  parameter int HEAP_BYTES   = 1024,
  parameter int HEADER_BYTES = 32,
  parameter bit IS_HEAD      = 1'b0
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ffba_pkg::ffba_ctl_t          ctl,
  input  ffba_pkg::ffba_sel_t          sel,
  input  logic [AW-1:0]                left_start,
  input  logic [AW-1:0]                left_size,
  input  logic                         left_used,
  input  logic                         left_valid,
  input  logic [AW-1:0]                right_start,
  input  logic [AW-1:0]                right_size,
  input  logic                         right_used,
  input  logic                         right_valid,
  output logic [AW-1:0]                start,
  output logic [AW-1:0]                size,
  output logic                         used,
  output logic                         valid,
  output logic                         fit,
  output logic                         match,
  output logic                         split_ok,
  output logic [ffba_pkg::OFF_W-1:0]   poff
);
  import ffba_pkg::*;

  localparam int CW = ((AW > REQ_W) ? AW : REQ_W) + 1;
  localparam logic [CW-1:0] HDR       = CW'(HEADER_BYTES);
  localparam logic [AW-1:0] INIT_SIZE = AW'(HEAP_BYTES - HEADER_BYTES);

  logic [CW-1:0] start_x, size_x, want_x, off_x, poff_x;
  logic [CW-1:0] left_start_x, left_size_x, right_size_x;
  logic [AW-1:0] start_next, size_next;
  logic          used_next, valid_next;

  assign start_x      = CW'(start);
  assign size_x       = CW'(size);
  assign want_x       = CW'(ctl.want);
  assign off_x        = CW'(ctl.offset);
  assign left_start_x = CW'(left_start);
  assign left_size_x  = CW'(left_size);
  assign right_size_x = CW'(right_size);
  assign poff_x       = start_x + HDR;

  assign fit      = valid & ~used & (size_x >= want_x);
  assign match    = valid & (poff_x == off_x);
  assign split_ok = (size_x - want_x) > HDR;
  assign poff     = poff_x[OFF_W-1:0];

  always_comb begin
    start_next = start;
    size_next  = size;
    used_next  = used;
    valid_next = valid;
    case (ctl.op)
      OP_ALLOC_SPLIT: begin
        if (sel.hit) begin
          size_next = AW'(want_x);
          used_next = 1'b1;
        end else if (sel.hit_left) begin
          // carve the free remainder out of the block below
          start_next = AW'(left_start_x + HDR + want_x);
          size_next  = AW'(left_size_x - want_x - HDR);
          used_next  = 1'b0;
          valid_next = 1'b1;
        end else if (sel.above) begin
          start_next = left_start;
          size_next  = left_size;
          used_next  = left_used;
          valid_next = left_valid;
        end
      end
      OP_ALLOC_WHOLE: begin
        if (sel.hit) used_next = 1'b1;
      end
      OP_MARK_FREE: begin
        if (sel.hit) used_next = 1'b0;
      end
      OP_MERGE_NEXT: begin
        if (sel.hit) begin
          used_next = 1'b0;
          size_next = AW'(size_x + HDR + right_size_x);
        end else if (sel.above) begin
          start_next = right_start;
          size_next  = right_size;
          used_next  = right_used;
          valid_next = right_valid;
        end
      end
      OP_MERGE_PREV: begin
        if (sel.hit_right) begin
          size_next = AW'(size_x + HDR + right_size_x);
        end else if (sel.hit || sel.above) begin
          start_next = right_start;
          size_next  = right_size;
          used_next  = right_used;
          valid_next = right_valid;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start <= '0;
      size  <= IS_HEAD ? INIT_SIZE : '0;
      used  <= 1'b0;
      valid <= IS_HEAD;
    end else begin
      start <= start_next;
      size  <= size_next;
      used  <= used_next;
      valid <= valid_next;
    end
  end

endmodule

// ----- design/ffba_ctrl.sv -----
`timescale 1ns / 1ps
// Request sequencer: first-fit select over the cell flags, op broadcast, result register.
// Depends on ffba_pkg; drives the cell row built in the top level.
module ffba_ctrl #(
  parameter int N = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [ffba_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  input  logic [0:0]                         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [ffba_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  output ffba_pkg::ffba_ctl_t                ctl,
  output ffba_pkg::ffba_sel_t                sel [N],
  input  logic [N-1:0]                       fit,
  input  logic [N-1:0]                       match,
  input  logic [N-1:0]                       split_ok,
  input  logic [N-1:0]                       used,
  input  logic [N-1:0]                       valid,
  input  logic [ffba_pkg::OFF_W-1:0]         poff [N]
);
  import ffba_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_FIND, S_APPLY, S_MERGE, S_DONE} state_t;

  state_t           state;
  logic             cmd_q;
  logic [REQ_W-1:0] want_q;
  logic [OFF_W-1:0] off_q;
  logic [N-1:0]     hit_q, above_q;
  logic             split_q, nfree_q, pfree_q;
  logic [ST_W-1:0]  status_q;
  logic [OFF_W-1:0] poff_q;

  logic [N-1:0]     cand, first, above, hit_l, hit_r;
  logic [N-1:0]     pcol [OFF_W];
  logic [OFF_W-1:0] first_poff;
  logic             any, hit_used, split, nfree, pfree;
  logic [ST_W-1:0]  status_c;

  // lowest set bit wins: isolate it and mask everything above it
  assign cand     = (cmd_q == CMD_FREE) ? match : fit;
  assign first    = cand & (~cand + N'(1));
  assign above    = ~(cand ^ (cand - N'(1)));
  assign any      = |cand;
  assign hit_used = |(first & used);
  assign split    = (|(first & split_ok)) & ~valid[N-1];
  assign nfree    = |((first << 1) & valid & ~used);
  assign pfree    = |((first >> 1) & valid & ~used);

  always_comb begin
    for (int b = 0; b < OFF_W; b++) begin
      for (int j = 0; j < N; j++) begin
        pcol[b][j] = first[j] & poff[j][b];
      end
    end
  end

  for (genvar b = 0; b < OFF_W; b++) begin : g_poff
    assign first_poff[b] = |pcol[b];
  end

  always_comb begin
    if (cmd_q == CMD_FREE) status_c = (any && hit_used) ? ST_OK : ST_BADFREE;
    else                   status_c = any ? ST_OK : ST_NOFIT;
  end

  assign hit_l = hit_q << 1;
  assign hit_r = hit_q >> 1;

  for (genvar j = 0; j < N; j++) begin : g_sel
    assign sel[j].hit       = hit_q[j];
    assign sel[j].hit_left  = hit_l[j];
    assign sel[j].hit_right = hit_r[j];
    assign sel[j].above     = above_q[j];
  end

  assign s_axis_tready = (state == S_IDLE);

  always_comb begin
    ctl.op     = OP_HOLD;
    ctl.want   = want_q;
    ctl.offset = off_q;
    case (state)
      S_APPLY: begin
        if (status_q == ST_OK) begin
          if (cmd_q == CMD_ALLOC) ctl.op = split_q ? OP_ALLOC_SPLIT : OP_ALLOC_WHOLE;
          else                    ctl.op = nfree_q ? OP_MERGE_NEXT : OP_MARK_FREE;
        end
      end
      S_MERGE: ctl.op = OP_MERGE_PREV;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      // the result state reloads the register itself
      if (m_axis_tvalid && m_axis_tready && state != S_DONE) m_axis_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            cmd_q  <= s_axis_tuser[0];
            want_q <= s_axis_tdata[REQ_W-1:0];
            off_q  <= s_axis_tdata[REQ_W+OFF_W-1:REQ_W];
            state  <= S_FIND;
          end
        end
        S_FIND: begin
          hit_q    <= first;
          above_q  <= above;
          split_q  <= split;
          nfree_q  <= nfree;
          pfree_q  <= pfree;
          status_q <= status_c;
          poff_q   <= (cmd_q == CMD_ALLOC && any) ? first_poff : '0;
          state    <= S_APPLY;
        end
        S_APPLY: begin
          if (cmd_q == CMD_FREE && status_q == ST_OK && pfree_q) state <= S_MERGE;
          else                                                   state <= S_DONE;
        end
        S_MERGE: state <= S_DONE;
        S_DONE: begin
          // hold until the result register is free
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {(OUT_DATA_W - OFF_W - ST_W)'(0), poff_q, status_q};
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- design/first_fit_block_allocator_top.sv -----
`timescale 1ns / 1ps
// Top level of the first-fit block allocator: a row of table cells and the sequencer.
// Depends on ffba_pkg, ffba_cell and ffba_ctrl.
//
//  channel  | signals          | contents (lowest bit first)
//  ---------+------------------+--------------------------------------------------
//  request  | s_axis_*         | tdata: req_size[10:0], user_offset[20:11]; tuser: cmd
//  result   | m_axis_*         | tdata: status[1:0], payload_offset[11:2]
//
// One request at a time. An allocate or a free goes through acceptance, first-fit select,
// table update and result load before the next acceptance; a free that also joins its
// lower neighbor adds one more shift pass through the cell row. A stalled result holds
// the sequencer in its result state. Reset is synchronous and leaves one free block
// spanning the heap less one header, in cell 0.
module first_fit_block_allocator_top #(
  parameter int HEAP_BYTES   = 1024,
  parameter int HEADER_BYTES = 32,
  parameter int MAX_BLOCKS   = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [ffba_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // req_size, user_offset
  input  logic [0:0]                         s_axis_tuser,  // cmd
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [ffba_pkg::OUT_DATA_W-1:0]    m_axis_tdata   // status, payload_offset
);
  import ffba_pkg::*;

  localparam int AW = $clog2(HEAP_BYTES);

  ffba_ctl_t           ctl;
  ffba_sel_t           sel [MAX_BLOCKS];
  logic [AW-1:0]       start_a [MAX_BLOCKS];
  logic [AW-1:0]       size_a  [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] used_v, valid_v, fit_v, match_v, split_v;
  logic [OFF_W-1:0]    poff_a  [MAX_BLOCKS];

  for (genvar j = 0; j < MAX_BLOCKS; j++) begin : g_cell
    logic [AW-1:0] l_start, l_size, r_start, r_size;
    logic          l_used, l_valid, r_used, r_valid;

    if (j == 0) begin : g_lo
      assign l_start = '0;
      assign l_size  = '0;
      assign l_used  = 1'b0;
      assign l_valid = 1'b0;
    end else begin : g_lo
      assign l_start = start_a[j-1];
      assign l_size  = size_a[j-1];
      assign l_used  = used_v[j-1];
      assign l_valid = valid_v[j-1];
    end

    if (j == MAX_BLOCKS - 1) begin : g_hi
      assign r_start = '0;
      assign r_size  = '0;
      assign r_used  = 1'b0;
      assign r_valid = 1'b0;
    end else begin : g_hi
      assign r_start = start_a[j+1];
      assign r_size  = size_a[j+1];
      assign r_used  = used_v[j+1];
      assign r_valid = valid_v[j+1];
    end

    ffba_cell #(
      .AW           (AW),
      .HEAP_BYTES   (HEAP_BYTES),
      .HEADER_BYTES (HEADER_BYTES),
      .IS_HEAD      (j == 0)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .sel         (sel[j]),
      .left_start  (l_start),
      .left_size   (l_size),
      .left_used   (l_used),
      .left_valid  (l_valid),
      .right_start (r_start),
      .right_size  (r_size),
      .right_used  (r_used),
      .right_valid (r_valid),
      .start       (start_a[j]),
      .size        (size_a[j]),
      .used        (used_v[j]),
      .valid       (valid_v[j]),
      .fit         (fit_v[j]),
      .match       (match_v[j]),
      .split_ok    (split_v[j]),
      .poff        (poff_a[j])
    );
  end

  ffba_ctrl #(
    .N (MAX_BLOCKS)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .ctl           (ctl),
    .sel           (sel),
    .fit           (fit_v),
    .match         (match_v),
    .split_ok      (split_v),
    .used          (used_v),
    .valid         (valid_v),
    .poff          (poff_a)
  );

endmodule

// ----- verif/ffba_checker.sv -----
`timescale 1ns / 1ps
// Checker for the first-fit block allocator: watches both stream channels, keeps its own
// copy of the block table, and compares every result with the predicted one.
// Depends on ffba_pkg.
module ffba_checker #(
  parameter int HEAP_BYTES   = 1024,
  parameter int HEADER_BYTES = 32,
  parameter int MAX_BLOCKS   = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [ffba_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // req_size, user_offset
  input  logic [0:0]                      s_axis_tuser,   // cmd
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [ffba_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // status, payload_offset
  input  logic                            drained,
  output int                              errors
);
  import ffba_pkg::*;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [OFF_W-1:0] payload;
  } reply_t;

  logic [REQ_W-1:0] heap_base [MAX_BLOCKS];
  logic [REQ_W-1:0] heap_len  [MAX_BLOCKS];
  bit               heap_busy [MAX_BLOCKS];
  int               heap_blocks;

  reply_t reply_due[$];
  int     fail_count = 0;
  bit     end_checked = 0;

  assign errors = fail_count;

  task automatic report(input string msg);
    fail_count++;
    if (fail_count <= 40) $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  function automatic void heap_clear();
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      heap_base[i] = '0;
      heap_len[i]  = '0;
      heap_busy[i] = 1'b0;
    end
    heap_len[0] = REQ_W'(HEAP_BYTES - HEADER_BYTES);
    heap_blocks = 1;
  endfunction

  // Close the gap left by entry k and zero the freed slot at the top.
  function automatic void drop_block(input int k);
    for (int i = k; i + 1 < heap_blocks; i++) begin
      heap_base[i] = heap_base[i+1];
      heap_len[i]  = heap_len[i+1];
      heap_busy[i] = heap_busy[i+1];
    end
    heap_blocks--;
    heap_base[heap_blocks] = '0;
    heap_len[heap_blocks]  = '0;
    heap_busy[heap_blocks] = 1'b0;
  endfunction

  function automatic reply_t heap_apply(input logic cmd, input logic [REQ_W-1:0] want,
                                        input logic [OFF_W-1:0] offset);
    reply_t r;
    int hit;
    int spare;
    r.status  = ST_OK;
    r.payload = '0;
    hit = -1;
    if (cmd == CMD_ALLOC) begin
      for (int i = 0; i < heap_blocks; i++)
        if (hit < 0 && !heap_busy[i] && heap_len[i] >= want) hit = i;
      if (hit < 0) begin
        r.status = ST_NOFIT;
      end else begin
        spare = int'(heap_len[hit]) - int'(want);
        if (spare > HEADER_BYTES && heap_blocks < MAX_BLOCKS) begin
          for (int k = heap_blocks; k > hit + 1; k--) begin
            heap_base[k] = heap_base[k-1];
            heap_len[k]  = heap_len[k-1];
            heap_busy[k] = heap_busy[k-1];
          end
          heap_blocks++;
          heap_base[hit+1] = REQ_W'(int'(heap_base[hit]) + HEADER_BYTES + int'(want));
          heap_len[hit+1]  = REQ_W'(spare - HEADER_BYTES);
          heap_busy[hit+1] = 1'b0;
          heap_len[hit]    = want;
        end
        heap_busy[hit] = 1'b1;
        // a zero-size block at the very top wraps its payload offset to 0
        r.payload = OFF_W'(int'(heap_base[hit]) + HEADER_BYTES);
      end
    end else begin
      for (int i = 0; i < heap_blocks; i++)
        if (hit < 0 && int'(heap_base[i]) + HEADER_BYTES == int'(offset)) hit = i;
      if (hit < 0 || !heap_busy[hit]) begin
        r.status = ST_BADFREE;
      end else begin
        heap_busy[hit] = 1'b0;
        if (hit + 1 < heap_blocks && !heap_busy[hit+1]) begin
          heap_len[hit] = REQ_W'(int'(heap_len[hit]) + HEADER_BYTES + int'(heap_len[hit+1]));
          drop_block(hit + 1);
        end
        if (hit > 0 && !heap_busy[hit-1]) begin
          heap_len[hit-1] = REQ_W'(int'(heap_len[hit-1]) + HEADER_BYTES + int'(heap_len[hit]));
          drop_block(hit);
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t got;
    reply_t want_r;
    if (rst) begin
      heap_clear();
      reply_due.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        reply_due.push_back(heap_apply(s_axis_tuser[0], s_axis_tdata[REQ_W-1:0],
                                       s_axis_tdata[REQ_W+OFF_W-1:REQ_W]));
      if (m_axis_tvalid && m_axis_tready) begin
        got.status  = m_axis_tdata[ST_W-1:0];
        got.payload = m_axis_tdata[ST_W+OFF_W-1:ST_W];
        if (reply_due.size() == 0) begin
          report($sformatf("result status=%0d offset=%0d with no request pending",
                           got.status, got.payload));
        end else begin
          want_r = reply_due.pop_front();
          if (got.status !== want_r.status)
            report($sformatf("status %0d, expected %0d", got.status, want_r.status));
          if (got.payload !== want_r.payload)
            report($sformatf("payload_offset %0d, expected %0d", got.payload,
                             want_r.payload));
        end
      end
      if (drained && !end_checked) begin
        end_checked = 1'b1;
        if (reply_due.size() != 0)
          report($sformatf("%0d results never arrived", reply_due.size()));
      end
    end
  end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// Top of the allocator testbench: clock, reset, request stimulus and result sink.
// Depends on ffba_pkg, first_fit_block_allocator_top and ffba_checker.
module testbench;
  import ffba_pkg::*;

  localparam int HEAP_BYTES   = 1024;
  localparam int HEADER_BYTES = 32;
  localparam int MAX_BLOCKS   = 32;
  localparam int ITEMS        = 1650;
  localparam int HOLD_AT      = 3000;
  localparam int HOLD_LEN     = 400;
  localparam int CALM_LO      = 6000;
  localparam int CALM_HI      = 7600;

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [0:0]            s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  stim_drained;
  int                    errors;

  int unsigned cyc = 0;
  logic        calm;
  int          sent = 0;
  logic        in_flight[$];
  logic [OFF_W-1:0] live_q[$];
  logic [OFF_W-1:0] freed_q[$];
  int n_alloc_ok = 0, n_nofit = 0, n_free_ok = 0, n_badfree = 0;

  first_fit_block_allocator_top #(
    .HEAP_BYTES  (HEAP_BYTES),
    .HEADER_BYTES(HEADER_BYTES),
    .MAX_BLOCKS  (MAX_BLOCKS)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  ffba_checker #(
    .HEAP_BYTES  (HEAP_BYTES),
    .HEADER_BYTES(HEADER_BYTES),
    .MAX_BLOCKS  (MAX_BLOCKS)
  ) u_checker (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .drained      (stim_drained),
    .errors       (errors)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) cyc <= cyc + 1;
  assign calm = (cyc >= CALM_LO) && (cyc < CALM_HI);

  initial begin
    #5_000_000;
    $display("Timeout with %0d requests sent and %0d results outstanding",
             sent, in_flight.size());
    $display("Simulation FAILED");
    $finish;
  end

  // Offer one request; idle at random first, hold until accepted.
  task automatic send_req(input logic cmd, input logic [REQ_W-1:0] sz,
                          input logic [OFF_W-1:0] off);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 34) begin
      s_axis_tvalid = 1'b0;
      s_axis_tdata  = IN_DATA_W'($urandom);
      s_axis_tuser  = 1'($urandom);
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {{(IN_DATA_W-REQ_W-OFF_W){1'b0}}, off, sz};
    s_axis_tuser  = cmd;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    in_flight.push_back(cmd);
    sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (in_flight.size() != 0) @(negedge clk);
  endtask

  function automatic logic [REQ_W-1:0] pick_size();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return REQ_W'($urandom_range(0, 64));
    if (roll < 95) return REQ_W'($urandom_range(0, 300));
    return REQ_W'($urandom_range(0, 1024));
  endfunction

  // Result sink: random stalls, one long hold-off, and tracking of live blocks.
  initial begin : result_sink
    int   hold_left;
    bit   hold_done;
    logic cmd;
    hold_left = 0;
    hold_done = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready && in_flight.size() != 0) begin
        cmd = in_flight.pop_front();
        if (cmd == CMD_ALLOC) begin
          if (m_axis_tdata[ST_W-1:0] == ST_OK) begin
            n_alloc_ok++;
            live_q.push_back(m_axis_tdata[ST_W+OFF_W-1:ST_W]);
          end else begin
            n_nofit++;
          end
        end else if (m_axis_tdata[ST_W-1:0] == ST_OK) begin
          n_free_ok++;
        end else begin
          n_badfree++;
        end
      end
      @(negedge clk);
      if (!hold_done && cyc >= HOLD_AT) begin
        hold_left = HOLD_LEN;
        hold_done = 1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = calm || ($urandom_range(0, 99) >= 34);
      end
    end
  end

  initial begin : stimulus
    int mode, run, roll, idx;
    bit paused;
    logic [OFF_W-1:0] off;
    paused = 0;
    rst = 1'b1;
    stim_drained = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = CMD_ALLOC;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_req(CMD_ALLOC, 11'd1024, 10'd1023); // too big even for the empty heap
    send_req(CMD_ALLOC, 11'd992, 10'd0);     // exact fit takes the whole heap
    send_req(CMD_ALLOC, 11'd0, 10'd0);       // nothing free
    send_req(CMD_FREE, 11'd1024, 10'd32);
    send_req(CMD_FREE, 11'd0, 10'd32);       // double free
    send_req(CMD_FREE, 11'd5, 10'd0);        // unknown offsets
    send_req(CMD_FREE, 11'd5, 10'd1023);
    send_req(CMD_ALLOC, 11'd0, 10'd1023);    // zero payload, splits the rest off
    send_req(CMD_ALLOC, 11'd940, 10'd0);     // remainder of 20 stays attached
    send_req(CMD_FREE, 11'd0, 10'd32);
    send_req(CMD_FREE, 11'd0, 10'd64);       // joins the free block below
    send_req(CMD_ALLOC, 11'd100, 10'd0);
    send_req(CMD_ALLOC, 11'd100, 10'd0);
    send_req(CMD_ALLOC, 11'd100, 10'd0);
    send_req(CMD_FREE, 11'd0, 10'd32);
    send_req(CMD_FREE, 11'd0, 10'd296);      // joins the free tail above
    send_req(CMD_FREE, 11'd0, 10'd164);      // three free blocks become one
    send_req(CMD_ALLOC, 11'd991, 10'd0);     // near fit, handed out unsplit
    send_req(CMD_FREE, 11'd0, 10'd32);
    wait_idle();
    live_q.delete();

    // Runs of filling, churning or draining, with some malformed frees and oversized allocations mixed in.
    while (sent < ITEMS) begin
      mode = $urandom_range(0, 2);
      run  = $urandom_range(20, 80);
      repeat (run) begin
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
          send_req(CMD_FREE, REQ_W'($urandom_range(0, 1024)), OFF_W'($urandom_range(0, 1023)));
        end else if (roll < 8 && freed_q.size() != 0) begin
          idx = $urandom_range(0, freed_q.size() - 1);
          send_req(CMD_FREE, REQ_W'($urandom_range(0, 1024)), freed_q[idx]);
        end else if (roll < 10) begin
          send_req(CMD_ALLOC, 11'd1024, OFF_W'($urandom_range(0, 1023)));
        end else if (live_q.size() == 0 ||
                     roll < (mode == 0 ? 80 : (mode == 1 ? 55 : 20))) begin
          send_req(CMD_ALLOC, pick_size(), OFF_W'($urandom_range(0, 1023)));
        end else begin
          idx = $urandom_range(0, live_q.size() - 1);
          off = live_q[idx];
          live_q.delete(idx);
          freed_q.push_back(off);
          if (freed_q.size() > 16) void'(freed_q.pop_front());
          send_req(CMD_FREE, REQ_W'($urandom_range(0, 1024)), off);
        end
      end
      if (!paused && sent >= 1000) begin
        paused = 1;
        wait_idle();
      end
    end

    wait_idle();
    repeat (20) @(negedge clk);
    stim_drained = 1'b1;
    repeat (2) @(negedge clk);
    $display("Sent %0d requests: %0d allocations granted, %0d without fit,", sent,
             n_alloc_ok, n_nofit);
    $display("%0d frees accepted and %0d rejected as unknown or double frees",
             n_free_ok, n_badfree);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
